[src/lpr_pkg.sv]
// Package for the line pixel rasterizer: coordinate and error widths, opcodes,
// the command record passed from front to back and the display size record.
// No dependencies.
`default_nettype none

package lpr_pkg;

   // coordinate, error term and display register widths
   localparam int COORD_BITS = 8;
   localparam int ERR_BITS   = COORD_BITS + 3;
   localparam int DISP_BITS  = COORD_BITS + 1;

   // configuration register indexes and reset values
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;
   localparam logic [DISP_BITS-1:0] DISP_WIDTH_RESET  = DISP_BITS'(128);
   localparam logic [DISP_BITS-1:0] DISP_HEIGHT_RESET = DISP_BITS'(64);

   // depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   // one classified item, set up for the back end
   typedef struct packed {
      op_type                       opcode;
      logic [COORD_BITS-1:0]        col_start;
      logic [COORD_BITS-1:0]        row_start;
      logic                         step_left;
      logic                         step_up;
      logic                         col_major;
      logic signed [ERR_BITS-1:0]   err_init;
      logic signed [ERR_BITS-1:0]   inc_keep;
      logic signed [ERR_BITS-1:0]   inc_step;
      logic [COORD_BITS-1:0]        pixel_count;
      logic                         color;
   } cmd_type;

   // display size as held by the register file
   typedef struct packed {
      logic [DISP_BITS-1:0] width;
      logic [DISP_BITS-1:0] height;
   } cfg_type;

endpackage

`default_nettype wire

[src/lpr_if.sv]
// Stream interfaces for the line pixel rasterizer: request items and pixel items.
// Depends on lpr_pkg for the coordinate width.
`default_nettype none

interface lpr_req_if;
   import lpr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [COORD_BITS-1:0] x_start;
   logic [COORD_BITS-1:0] y_start;
   logic [COORD_BITS-1:0] x_end;
   logic [COORD_BITS-1:0] y_end;
   logic                  pen_color;

   modport source (output valid, opcode, x_start, y_start, x_end, y_end, pen_color,
                   input ready);
   modport sink   (input valid, opcode, x_start, y_start, x_end, y_end, pen_color,
                   output ready);
endinterface

interface lpr_rsp_if;
   import lpr_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  pixel_valid;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic                  pixel_color;
   logic                  on_screen;
   logic                  last_pixel;

   modport source (output valid, pixel_valid, pixel_x, pixel_y, pixel_color, on_screen,
                   last_pixel, input ready);
   modport sink   (input valid, pixel_valid, pixel_x, pixel_y, pixel_color, on_screen,
                   last_pixel, output ready);
endinterface

`default_nettype wire

[src/line_pixel_rasterizer.sv]
// Top level of the line pixel rasterizer: register file, front end, command queue
// and pixel stepper. Depends on lpr_pkg, lpr_if, lpr_front, lpr_cmd_queue, lpr_back.
`default_nettype none

// Bresenham line rasterizer for all octants. A start item (opcode 0) loads two
// endpoints and a pen color and returns the first endpoint as a pixel; each advance
// item (opcode 1) returns the next pixel, and the pixel on the second endpoint has
// last_pixel set. An advance with no line in progress returns an item with every
// field zero. Every request gives exactly one pixel item. The block takes one item
// per clock and returns one pixel per clock while the pixel output is not stalled;
// a request passes through the command queue and then the stepper's output register
// before its pixel appears. The rate is set by the stepper's error-term update.
// Registers: display_width at byte address 0 and display_height at byte address 4,
// 9 bits each, reset 128 and 64; a pixel is on screen when x and y are below them.
// Write the registers only while no items are in flight.

module line_pixel_rasterizer
   import lpr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lpr_req_if.sink     req_bus,
   lpr_rsp_if.source   rsp_bus,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    csr_write;
   logic    csr_index;

   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IDX_WIDTH:  cfg_in.width  = csr_pwdata[DISP_BITS-1:0];
            CSR_IDX_HEIGHT: cfg_in.height = csr_pwdata[DISP_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= DISP_WIDTH_RESET;
         cfg_ff.height <= DISP_HEIGHT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read back
   always_comb begin
      unique case (csr_index)
         CSR_IDX_WIDTH:  csr_prdata = {{(32-DISP_BITS){1'b0}}, cfg_ff.width};
         CSR_IDX_HEIGHT: csr_prdata = {{(32-DISP_BITS){1'b0}}, cfg_ff.height};
         default:        csr_prdata = '0;
      endcase
   end

   lpr_front u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   lpr_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   lpr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_bus   (rsp_bus)
   );

endmodule

`default_nettype wire

[src/lpr_front.sv]
// Front end: accepts request items, classifies them and sets up line parameters.
// Depends on lpr_pkg and lpr_req_if.
`default_nettype none

module lpr_front
   import lpr_pkg::*;
(
   lpr_req_if.sink   req_bus,
   output logic      push_valid,
   input  logic      push_ready,
   output cmd_type   push_cmd
);

   logic                  left;
   logic                  up;
   logic [COORD_BITS-1:0] dcol;
   logic [COORD_BITS-1:0] drow;
   logic                  major_col;
   logic [COORD_BITS-1:0] major;
   logic [COORD_BITS-1:0] minor;
   logic signed [ERR_BITS-1:0] two_minor;
   logic signed [ERR_BITS-1:0] two_major;
   logic signed [ERR_BITS-1:0] one_major;

   // hand items straight to the queue while it has room
   assign push_valid    = req_bus.valid;
   assign req_bus.ready = push_ready;

   // absolute deltas, step directions and major axis
   always_comb begin
      left      = req_bus.x_start > req_bus.x_end;
      up        = req_bus.y_start > req_bus.y_end;
      dcol      = left ? req_bus.x_start - req_bus.x_end : req_bus.x_end - req_bus.x_start;
      drow      = up   ? req_bus.y_start - req_bus.y_end : req_bus.y_end - req_bus.y_start;
      major_col = dcol >= drow;
      major     = major_col ? dcol : drow;
      minor     = major_col ? drow : dcol;
      two_minor = $signed({2'b00, minor, 1'b0});
      two_major = $signed({2'b00, major, 1'b0});
      one_major = $signed({3'b000, major});
   end

   // build the command record
   always_comb begin
      push_cmd.opcode      = req_bus.opcode ? OP_ADVANCE : OP_START;
      push_cmd.col_start   = req_bus.x_start;
      push_cmd.row_start   = req_bus.y_start;
      push_cmd.step_left   = left;
      push_cmd.step_up     = up;
      push_cmd.col_major   = major_col;
      push_cmd.err_init    = two_minor - one_major;
      push_cmd.inc_keep    = two_minor;
      push_cmd.inc_step    = two_minor - two_major;
      push_cmd.pixel_count = major;
      push_cmd.color       = req_bus.pen_color;
   end

endmodule

`default_nettype wire

[src/lpr_cmd_queue.sv]
// Short command queue between the front end and the pixel stepper.
// Depends on lpr_pkg for the command record and queue depth.
`default_nettype none

module lpr_cmd_queue
   import lpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff;
   logic [QCNT_BITS-1:0]   count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[src/lpr_back.sv]
// Back end: holds the line state, steps at most one pixel per command and
// registers the outgoing pixel item. Depends on lpr_pkg and lpr_rsp_if.
`default_nettype none

module lpr_back
   import lpr_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  cmd_type   pop_cmd,
   lpr_rsp_if.source rsp_bus
);

   // line state
   logic [COORD_BITS-1:0]      cur_col_ff,     cur_col_in;
   logic [COORD_BITS-1:0]      cur_row_ff,     cur_row_in;
   logic signed [ERR_BITS-1:0] err_ff,         err_in;
   logic signed [ERR_BITS-1:0] inc_keep_ff,    inc_keep_in;
   logic signed [ERR_BITS-1:0] inc_step_ff,    inc_step_in;
   logic                       step_left_ff,   step_left_in;
   logic                       step_up_ff,     step_up_in;
   logic                       col_major_ff,   col_major_in;
   logic [COORD_BITS-1:0]      pixels_left_ff, pixels_left_in;
   logic                       busy_ff,        busy_in;
   logic                       color_ff,       color_in;

   // output register
   logic                       rsp_valid_ff,   rsp_valid_in;
   logic                       pix_valid_ff,   pix_valid_in;
   logic [COORD_BITS-1:0]      pix_x_ff,       pix_x_in;
   logic [COORD_BITS-1:0]      pix_y_ff,       pix_y_in;
   logic                       pix_color_ff,   pix_color_in;
   logic                       pix_on_ff,      pix_on_in;
   logic                       pix_last_ff,    pix_last_in;

   logic                       fire;
   logic                       err_neg;
   logic [COORD_BITS-1:0]      col_moved;
   logic [COORD_BITS-1:0]      row_moved;

   // take a command whenever the output register is free or draining
   assign pop_ready = !rsp_valid_ff || rsp_bus.ready;
   assign fire      = pop_valid && pop_ready;

   assign err_neg   = err_ff[ERR_BITS-1];
   assign col_moved = step_left_ff ? cur_col_ff - 1'b1 : cur_col_ff + 1'b1;
   assign row_moved = step_up_ff   ? cur_row_ff - 1'b1 : cur_row_ff + 1'b1;

   // execute start and advance commands
   always_comb begin
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      err_in         = err_ff;
      inc_keep_in    = inc_keep_ff;
      inc_step_in    = inc_step_ff;
      step_left_in   = step_left_ff;
      step_up_in     = step_up_ff;
      col_major_in   = col_major_ff;
      pixels_left_in = pixels_left_ff;
      busy_in        = busy_ff;
      color_in       = color_ff;
      pix_valid_in   = pix_valid_ff;
      pix_x_in       = pix_x_ff;
      pix_y_in       = pix_y_ff;
      pix_color_in   = pix_color_ff;
      pix_last_in    = pix_last_ff;
      if (fire) begin
         if (pop_cmd.opcode == OP_START) begin
            // drop any line in progress and load the new one
            cur_col_in     = pop_cmd.col_start;
            cur_row_in     = pop_cmd.row_start;
            err_in         = pop_cmd.err_init;
            inc_keep_in    = pop_cmd.inc_keep;
            inc_step_in    = pop_cmd.inc_step;
            step_left_in   = pop_cmd.step_left;
            step_up_in     = pop_cmd.step_up;
            col_major_in   = pop_cmd.col_major;
            pixels_left_in = pop_cmd.pixel_count;
            busy_in        = pop_cmd.pixel_count != '0;
            color_in       = pop_cmd.color;
            pix_valid_in   = 1'b1;
            pix_x_in       = pop_cmd.col_start;
            pix_y_in       = pop_cmd.row_start;
            pix_color_in   = pop_cmd.color;
            pix_last_in    = pop_cmd.pixel_count == '0;
         end else if (busy_ff) begin
            // step the major axis, and the minor one when the error term allows
            if (err_neg) begin
               err_in = err_ff + inc_keep_ff;
            end else begin
               err_in = err_ff + inc_step_ff;
            end
            if (col_major_ff) begin
               cur_col_in = col_moved;
               if (!err_neg) begin
                  cur_row_in = row_moved;
               end
            end else begin
               cur_row_in = row_moved;
               if (!err_neg) begin
                  cur_col_in = col_moved;
               end
            end
            pixels_left_in = pixels_left_ff - 1'b1;
            busy_in        = pixels_left_ff != COORD_BITS'(1);
            pix_valid_in   = 1'b1;
            pix_x_in       = cur_col_in;
            pix_y_in       = cur_row_in;
            pix_color_in   = color_ff;
            pix_last_in    = pixels_left_ff == COORD_BITS'(1);
         end else begin
            // advance with no line: empty item
            pix_valid_in = 1'b0;
            pix_x_in     = '0;
            pix_y_in     = '0;
            pix_color_in = 1'b0;
            pix_last_in  = 1'b0;
         end
      end
   end

   // on-screen test against the display size
   always_comb begin
      pix_on_in = pix_on_ff;
      if (fire) begin
         pix_on_in = pix_valid_in
                     && ({1'b0, pix_x_in} < cfg.width)
                     && ({1'b0, pix_y_in} < cfg.height);
      end
   end

   // hold the item until it is taken
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff     <= cur_col_in;
      cur_row_ff     <= cur_row_in;
      err_ff         <= err_in;
      inc_keep_ff    <= inc_keep_in;
      inc_step_ff    <= inc_step_in;
      step_left_ff   <= step_left_in;
      step_up_ff     <= step_up_in;
      col_major_ff   <= col_major_in;
      pixels_left_ff <= pixels_left_in;
      color_ff       <= color_in;
      pix_valid_ff   <= pix_valid_in;
      pix_x_ff       <= pix_x_in;
      pix_y_ff       <= pix_y_in;
      pix_color_ff   <= pix_color_in;
      pix_on_ff      <= pix_on_in;
      pix_last_ff    <= pix_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pixel_valid = pix_valid_ff;
   assign rsp_bus.pixel_x     = pix_x_ff;
   assign rsp_bus.pixel_y     = pix_y_ff;
   assign rsp_bus.pixel_color = pix_color_ff;
   assign rsp_bus.on_screen   = pix_on_ff;
   assign rsp_bus.last_pixel  = pix_last_ff;

endmodule

`default_nettype wire

[src/lpr_checker.sv]
// Port-level checker for the line pixel rasterizer, bound to the top level.
// Depends on lpr_pkg for the coordinate width.
`default_nettype none

module lpr_checker
   import lpr_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  pixel_valid,
   input logic [COORD_BITS-1:0] pixel_x,
   input logic [COORD_BITS-1:0] pixel_y,
   input logic                  pixel_color,
   input logic                  on_screen,
   input logic                  last_pixel
);

   // a stalled pixel item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pixel_x) && $stable(pixel_y)
         && $stable(pixel_valid) && $stable(last_pixel) && $stable(on_screen))
      else $error("pixel item changed while stalled");

   // an empty item carries all-zero fields
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0 && !pixel_color
         && !on_screen && !last_pixel)
      else $error("empty item with nonzero fields");

   // reset leaves no item pending
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel item pending after reset");

   // the queue is empty after reset and takes items
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request side not ready after reset");

endmodule

bind line_pixel_rasterizer lpr_checker u_lpr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .pixel_valid (rsp_bus.pixel_valid),
   .pixel_x     (rsp_bus.pixel_x),
   .pixel_y     (rsp_bus.pixel_y),
   .pixel_color (rsp_bus.pixel_color),
   .on_screen   (rsp_bus.on_screen),
   .last_pixel  (rsp_bus.last_pixel)
);

`default_nettype wire
